FILE: rtl/vslru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vslru_pkg: shared types and codes
// Request codes and the command and status records that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package vslru_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  typedef struct packed {
    logic capture;
    logic flush;
    logic cap_write;
    logic lookup;
    logic evict;
    logic insert;
    logic promote;
  } vslru_cmd_t;

  typedef struct packed {
    logic too_large;
    logic found;
    logic need_evict;
    logic any_valid;
    logic is_load;
    logic is_query;
    logic is_flush;
  } vslru_status_t;

endpackage

FILE: rtl/vslru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vslru_req_if / vslru_rsp_if: request and result channels
// Valid/ready channels carrying the request and the result transaction.
// ----------------------------------------------------------------------------
interface vslru_req_if #(parameter int ID_BITS = 16, parameter int SIZE_BITS = 24);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ID_BITS-1:0]   kernel_id;
  logic [SIZE_BITS-1:0] kernel_size;
  modport source (output valid, req_type, kernel_id, kernel_size, input ready);
  modport sink   (input valid, req_type, kernel_id, kernel_size, output ready);
endinterface

interface vslru_rsp_if #(parameter int SIZE_BITS = 24);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 too_large;
  logic [SIZE_BITS-1:0] free_bytes_now;
  logic [4:0]           evicted_count;
  modport source (output valid, hit, too_large, free_bytes_now, evicted_count, input ready);
  modport sink   (input valid, hit, too_large, free_bytes_now, evicted_count, output ready);
endinterface

FILE: rtl/vslru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vslru_ctrl: request sequencer
// Steps one transaction through lookup, eviction, insertion and response.
// ----------------------------------------------------------------------------
module vslru_ctrl
  import vslru_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_we,
  input  vslru_status_t sts,
  output vslru_cmd_t    cmd
);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EVICT, S_DONE, S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.cap_write = cfg_we;
    case (state_r)
      S_LOOK: begin
        if (sts.is_flush) cmd.flush = 1'b1;
        else if (sts.is_load && !sts.too_large && sts.found) cmd.promote = 1'b1;
      end
      S_EVICT: begin
        if (sts.need_evict && sts.any_valid) cmd.evict = 1'b1;
        else cmd.insert = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) state_r <= S_LOOK;
        S_LOOK: begin
          if (sts.is_load && !sts.too_large && !sts.found) state_r <= S_EVICT;
          else state_r <= S_DONE;
        end
        S_EVICT: if (!(sts.need_evict && sts.any_valid)) state_r <= S_DONE;
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/vslru_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vslru_dp: entry table datapath
// Holds the slot table, free byte count and the result fields.
// ----------------------------------------------------------------------------
module vslru_dp
  import vslru_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int ID_BITS   = 16,
  parameter int SIZE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vslru_cmd_t           cmd,
  output vslru_status_t        sts,
  input  logic [SIZE_BITS-1:0] cfg_data,
  input  logic [1:0]           in_req_type,
  input  logic [ID_BITS-1:0]   in_kernel_id,
  input  logic [SIZE_BITS-1:0] in_kernel_size,
  output logic                 out_hit,
  output logic                 out_too_large,
  output logic [SIZE_BITS-1:0] out_free_bytes_now,
  output logic [4:0]           out_evicted_count
);

  localparam int RW = $clog2(ENTRIES);

  logic [ENTRIES-1:0]   valid_r;
  logic [ID_BITS-1:0]   key_r   [ENTRIES];
  logic [SIZE_BITS-1:0] bytes_r [ENTRIES];
  logic [RW-1:0]        rank_r  [ENTRIES];
  logic [SIZE_BITS-1:0] cap_r, free_r;
  logic [1:0]           req_r;
  logic [ID_BITS-1:0]   id_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 hit_r, big_r;
  logic [4:0]           evc_r;

  logic [ENTRIES-1:0] match, is_old;
  logic [RW-1:0]      hit_rank, old_idx, free_idx;
  logic [SIZE_BITS-1:0] old_bytes;
  logic               all_full;

  always_comb begin
    hit_rank = '0;
    old_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == id_r);
      is_old[i] = valid_r[i] && (rank_r[i] == RW'($countones(valid_r) - 1));
      if (match[i]) hit_rank = rank_r[i];
      if (is_old[i]) old_idx = RW'(i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!valid_r[i]) free_idx = RW'(i);
  end

  assign old_bytes = bytes_r[old_idx];
  assign all_full  = &valid_r;

  assign sts.too_large  = size_r > cap_r;
  assign sts.found      = |match;
  assign sts.need_evict = (size_r > free_r) || all_full;
  assign sts.any_valid  = |valid_r;
  assign sts.is_load    = req_r == REQ_LOAD;
  assign sts.is_query   = req_r == REQ_QUERY;
  assign sts.is_flush   = req_r == REQ_FLUSH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cap_r   <= SIZE_BITS'(2097152);
      free_r  <= SIZE_BITS'(2097152);
    end else if (cmd.cap_write) begin
      valid_r <= '0;
      cap_r   <= cfg_data;
      free_r  <= cfg_data;
    end else begin
      if (cmd.flush) begin
        valid_r <= '0;
        free_r  <= cap_r;
      end
      if (cmd.promote) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_r[i] && rank_r[i] < hit_rank) rank_r[i] <= rank_r[i] + 1'b1;
          else if (match[i]) rank_r[i] <= '0;
      end
      if (cmd.evict) begin
        valid_r[old_idx] <= 1'b0;
        free_r           <= free_r + old_bytes;
      end
      if (cmd.insert) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
          else if (RW'(i) == free_idx) rank_r[i] <= '0;
        valid_r[free_idx] <= 1'b1;
        key_r[free_idx]   <= id_r;
        bytes_r[free_idx] <= size_r;
        free_r <= (size_r <= free_r) ? free_r - size_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      id_r   <= in_kernel_id;
      size_r <= in_kernel_size;
      hit_r  <= 1'b0;
      big_r  <= 1'b0;
      evc_r  <= '0;
    end else begin
      if (cmd.promote) hit_r <= 1'b1;
      if (sts.is_query && !cmd.evict && !cmd.insert) hit_r <= sts.found;
      if (sts.is_load && sts.too_large) big_r <= 1'b1;
      if (cmd.evict) evc_r <= evc_r + 5'd1;
    end
  end

  assign out_hit            = hit_r;
  assign out_too_large      = big_r;
  assign out_free_bytes_now = free_r;
  assign out_evicted_count  = evc_r;

endmodule

FILE: rtl/variable_size_lru_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_size_lru_cache_top: byte-capacity LRU residency tracker
// A load that misses steps through the lookup, evict and done states before
// its result comes out; the eviction loop retires one entry a cycle and then
// inserts the new one. Every other request goes from lookup straight to done.
// The next request is accepted in the cycle after the result is taken. A
// write of the capacity register empties the table. Free bytes come out as
// reported after the request.
// ----------------------------------------------------------------------------
module variable_size_lru_cache_top
  import vslru_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int ID_BITS   = 16,
  parameter int SIZE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [SIZE_BITS-1:0] cfg_data,
  vslru_req_if.sink            in_ch,
  vslru_rsp_if.source          out_ch
);

  vslru_cmd_t    cmd;
  vslru_status_t sts;

  vslru_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cfg_we, .sts, .cmd
  );

  vslru_dp #(.ENTRIES(ENTRIES), .ID_BITS(ID_BITS), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_data,
    .in_req_type       (in_ch.req_type),
    .in_kernel_id      (in_ch.kernel_id),
    .in_kernel_size    (in_ch.kernel_size),
    .out_hit           (out_ch.hit),
    .out_too_large     (out_ch.too_large),
    .out_free_bytes_now(out_ch.free_bytes_now),
    .out_evicted_count (out_ch.evicted_count)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input accepted while result pending");
  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.too_large)) else $error("hit with too_large");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.evicted_count <= 5'(ENTRIES)) else $error("eviction count");

endmodule

FILE: test/variable_size_lru_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_size_lru_cache_top_tb: self-checking bench for the LRU tracker
// Loads, queries, flushes and no-ops go in over the request channel under
// random gaps and result stalls. A behavioral copy of the table predicts
// every result, and the results are compared field by field in arrival order.
// The capacity register is written between phases, with the extremes
// among the values.
// ----------------------------------------------------------------------------
module variable_size_lru_cache_top_tb
  import vslru_pkg::*;
();

  localparam int SLOTS   = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] kernel_id;
    logic [23:0] kernel_size;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic        too_large;
    logic [23:0] free_bytes_now;
    logic [4:0]  evicted_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;

  vslru_req_if #(.ID_BITS(16), .SIZE_BITS(24)) in_ch ();
  vslru_rsp_if #(.SIZE_BITS(24)) out_ch ();

  variable_size_lru_cache_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Table model.
  logic [23:0] cap_bytes;
  logic        slot_used [SLOTS];
  logic [15:0] slot_key [SLOTS];
  logic [23:0] slot_bytes [SLOTS];
  int          slot_age [SLOTS];
  logic [23:0] bytes_free;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int mismatches = 0;
  int accepted_reqs = 0;
  int checked_outcomes = 0;
  int hit_seen = 0;
  int evict_seen = 0;
  bit long_stall = 1'b0;
  int idle_cycles = 0;

  function automatic void empty_table();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    bytes_free = cap_bytes;
  endfunction

  function automatic outcome_t lru_apply(request_t r);
    outcome_t o;
    int slot;
    int used;
    int pick;
    o = '0;
    slot = -1;
    if (r.req_type == REQ_LOAD) begin
      if (r.kernel_size > cap_bytes) begin
        o.too_large = 1'b1;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i] && slot_key[i] == r.kernel_id) slot = i;
        if (slot >= 0) begin
          o.hit = 1'b1;
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] < slot_age[slot]) slot_age[i]++;
          slot_age[slot] = 0;
        end else begin
          forever begin
            used = 0;
            for (int i = 0; i < SLOTS; i++) if (slot_used[i]) used++;
            if (!(r.kernel_size > bytes_free || used >= SLOTS)) break;
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
              if (slot_used[i] && (pick < 0 || slot_age[i] > slot_age[pick])) pick = i;
            if (pick < 0) break;
            slot_used[pick] = 1'b0;
            bytes_free = bytes_free + slot_bytes[pick];
            o.evicted_count++;
          end
          for (int i = 0; i < SLOTS; i++) if (slot_used[i]) slot_age[i]++;
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_key[i] = r.kernel_id;
              slot_bytes[i] = r.kernel_size;
              slot_age[i] = 0;
              break;
            end
          end
          bytes_free = (r.kernel_size <= bytes_free) ? bytes_free - r.kernel_size : '0;
        end
      end
    end else if (r.req_type == REQ_QUERY) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && slot_key[i] == r.kernel_id) o.hit = 1'b1;
    end else if (r.req_type == REQ_FLUSH) begin
      empty_table();
    end
    o.free_bytes_now = bytes_free;
    return o;
  endfunction

  // Driver: bursts and gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req_type <= '0;
      in_ch.kernel_id <= '0;
      in_ch.kernel_size <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_outcomes.push_back(lru_apply(pending_reqs.pop_front()));
        accepted_reqs++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.req_type <= pending_reqs[0].req_type;
        in_ch.kernel_id <= pending_reqs[0].kernel_id;
        in_ch.kernel_size <= pending_reqs[0].kernel_size;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver with its own stall pattern.
  logic [7:0] stall_pattern = 8'b1011_0110;
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (long_stall) out_ch.ready <= 1'b0;
      else if (stall_phase[9]) out_ch.ready <= 1'b1;
      else out_ch.ready <= stall_pattern[stall_phase % 8] | ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor.
  outcome_t got;
  outcome_t want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.hit, out_ch.too_large, out_ch.free_bytes_now, out_ch.evicted_count};
      checked_outcomes++;
      if (got.hit) hit_seen++;
      if (got.evicted_count != 0) evict_seen++;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b big=%0b free=%0d ev=%0d, got hit=%0b big=%0b free=%0d ev=%0d",
                     want.hit, want.too_large, want.free_bytes_now, want.evicted_count,
                     got.hit, got.too_large, got.free_bytes_now, got.evicted_count);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("variable_size_lru_cache_top_tb: done, errors");
      $finish;
    end
  end

  task automatic queue_req(input logic [1:0] t, input logic [15:0] id, input logic [23:0] sz);
    request_t r;
    r.req_type = t;
    r.kernel_id = id;
    r.kernel_size = sz;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [23:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_bytes = value;
    empty_table();
    @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int id_span, input logic [23:0] size_top);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60)
        queue_req(REQ_LOAD, 16'($urandom_range(0, id_span)), 24'($urandom_range(0, size_top)));
      else if (kind < 85)
        queue_req(REQ_QUERY, 16'($urandom_range(0, id_span)), 24'($urandom));
      else if (kind < 88)
        queue_req(REQ_FLUSH, 16'($urandom), 24'($urandom));
      else if (kind < 91)
        queue_req(REQ_NOP, 16'($urandom), 24'($urandom));
      else
        queue_req(REQ_LOAD, 16'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.kernel_id = '0;
    in_ch.kernel_size = '0;
    out_ch.ready = 1'b0;
    cap_bytes = 24'd2097152;
    empty_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset capacity, extremes, hits, full table, odd codes.
    queue_req(REQ_LOAD, 16'hFFFF, 24'hFFFFFF);
    queue_req(REQ_LOAD, 16'h0000, 24'd2097152);
    queue_req(REQ_LOAD, 16'h0000, 24'd5);
    queue_req(REQ_QUERY, 16'h0000, 24'd0);
    queue_req(REQ_LOAD, 16'h0001, 24'd1);
    queue_req(REQ_LOAD, 16'h0002, 24'd0);
    for (int i = 3; i < 19; i++) queue_req(REQ_LOAD, 16'(i), 24'd16);
    queue_req(REQ_QUERY, 16'hFFFF, 24'd0);
    queue_req(REQ_NOP, 16'h1234, 24'd77);
    queue_req(REQ_FLUSH, 16'h0, 24'd0);
    drain();

    write_capacity(24'hFFFFFF);
    random_phase(150, 40, 24'h1FFFFF);
    write_capacity(24'd0);
    random_phase(60, 8, 24'd1);
    write_capacity(24'd1);
    random_phase(60, 8, 24'd2);
    write_capacity(24'd1000);
    random_phase(300, 30, 24'd300);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        long_stall = 1'b1;
        repeat (300) @(posedge clk);
        long_stall = 1'b0;
      end
    join_none
    random_phase(100, 30, 24'd300);
    drain();

    write_capacity(24'd2097152);
    random_phase(250, 24, 24'h080000);
    drain();

    $display("covered %0d requests, %0d results checked, %0d hits, %0d evicting loads",
             accepted_reqs, checked_outcomes, hit_seen, evict_seen);
    if (mismatches == 0 && expected_outcomes.size() == 0)
      $display("variable_size_lru_cache_top_tb: done, clean");
    else
      $display("variable_size_lru_cache_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/vslru_pkg.sv
rtl/vslru_if.sv
rtl/vslru_ctrl.sv
rtl/vslru_dp.sv
rtl/variable_size_lru_cache_top.sv
test/variable_size_lru_cache_top_tb.sv
